>>> rtl/core/dsac_pkg.sv
// Package for the dual-slot animation crossfade block.
// Holds the transfer payload types, the operation and register codes and
// datapath widths. It depends on nothing.
`default_nettype none

package dsac_pkg;

	// Fixed-point position format and field widths
	localparam int POS_FRAC_BITS = 16;
	localparam int POS_W         = 32;
	localparam int DT_W          = 20;
	localparam int FT_W          = 20;
	localparam int FR_W          = 16;
	localparam int DUR_W         = 24;
	localparam int FADE_W        = 24;
	localparam int FACT_W        = 17;
	localparam int FACT_FRAC     = 16;
	localparam int SLOT_CNT      = 2;

	// Datapath widths derived from the position format
	localparam int DELTA_W    = DT_W + POS_FRAC_BITS;
	localparam int IDX_W      = ((DELTA_W > POS_W) ? DELTA_W : POS_W) + 1;
	localparam int HI_W       = IDX_W - POS_FRAC_BITS;
	localparam int WRAP_W     = FR_W + POS_FRAC_BITS;
	localparam int FNUM_W     = FADE_W + FACT_FRAC;
	localparam int DIV_NW_A   = (DELTA_W > HI_W) ? DELTA_W : HI_W;
	localparam int DIV_NW     = (DIV_NW_A > FNUM_W) ? DIV_NW_A : FNUM_W;
	localparam int DIV_DW_A   = (FT_W > FR_W) ? FT_W : FR_W;
	localparam int DIV_DW     = (DIV_DW_A > DUR_W) ? DIV_DW_A : DUR_W;
	localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);
	localparam int CFG_DATA_W = DUR_W;

	localparam logic [FACT_W-1:0] FACT_ONE = FACT_W'(1) << FACT_FRAC;

	// Operation codes
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_PUSH   = 2'd1,
		OP_SWITCH = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic CFG_BLEND_DURATION = 1'b0;
	localparam logic CFG_BLEND_CURVE    = 1'b1;

	// Input item
	typedef struct packed {
		logic [1:0]      operation;
		logic [DT_W-1:0] tick_us;
		logic            anim_present;
		logic [FR_W-1:0] anim_frames;
		logic [FT_W-1:0] anim_frame_time_us;
		logic            anim_loops;
		logic            anim_manual;
		logic            anim_blend_in_ok;
		logic            anim_blend_out_ok;
		logic            target_slot;
		logic [POS_W-1:0] new_position;
	} dsac_in_t;

	// Result item
	typedef struct packed {
		logic [FACT_W-1:0] fade_factor;
		logic [POS_W-1:0]  position_a;
		logic [POS_W-1:0]  position_b;
		logic              a_occupied;
		logic              b_occupied;
	} dsac_out_t;

	// Per-slot animation description
	typedef struct packed {
		logic            occupied;
		logic            loops;
		logic            manual;
		logic            in_ok;
		logic            out_ok;
		logic [FR_W-1:0] frames;
		logic [FT_W-1:0] frame_time;
	} slot_t;

	// Saturate a wide position to the 32-bit port range
	function automatic logic [POS_W-1:0] sat_pos(input logic [IDX_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v > IDX_W'({POS_W{1'b1}})) begin
			r = {POS_W{1'b1}};
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/dual_slot_animation_crossfade.sv
// Dual-slot animation crossfade controller: slot state, fade timer and one
// shared restoring divider run by a small sequencer. Depends on dsac_pkg.
// Push, switch and set compute the fade factor in the divider, saturate it and, with the
// squared curve, square it; zero blend duration skips all three. A tick first steps slots
// A and B (divide and add, a modulo divide when looping), then the fade timer and factor.
// Throughput: one item at a time; in_stall stays high until the result sits in the
// output register. Reset clears both slots, the fade timer and the configuration at once.
`default_nettype none

module dual_slot_animation_crossfade (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire dsac_pkg::dsac_in_t in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dsac_pkg::dsac_out_t    out_item,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [dsac_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dsac_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_EXEC   = 14'h0002,
		S_SLOT   = 14'h0004,
		S_DIVD   = 14'h0008,
		S_ADD    = 14'h0010,
		S_POS    = 14'h0020,
		S_DIVM   = 14'h0040,
		S_WRAP   = 14'h0080,
		S_FADE   = 14'h0100,
		S_FACTOR = 14'h0200,
		S_DIVF   = 14'h0400,
		S_SAT    = 14'h0800,
		S_SQR    = 14'h1000,
		S_OUT    = 14'h2000
	} state_t;

	state_t              state_q, state_d;
	logic                slot_sel_q;
	dsac_in_t            item_q;
	slot_t               slots_q [SLOT_CNT];
	logic [POS_W-1:0]    pos_q [SLOT_CNT];
	logic [FADE_W-1:0]   fade_q;
	logic [DUR_W-1:0]    dur_q;
	logic                curve_q;
	logic [DIV_NW-1:0]   div_num_q;
	logic [DIV_DW-1:0]   div_rem_q;
	logic [DIV_DW-1:0]   div_den_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [FACT_W-1:0]   fact_q;
	logic                out_valid_q;
	dsac_out_t           out_item_q;

	slot_t               cur;
	logic [FT_W-1:0]     ft_eff;
	logic [FR_W-1:0]     fr_eff;
	logic                slot_go;
	logic                slot_done;
	logic                div_ld;
	logic [DIV_NW-1:0]   div_ld_num;
	logic [DIV_DW-1:0]   div_ld_den;
	logic [DIV_CNT_W-1:0] div_ld_cnt;
	logic                div_run;
	logic [DIV_DW+1:0]   div_sub;
	logic                div_ge;
	logic [WRAP_W-1:0]   last_pos;
	logic [IDX_W-1:0]    clamp_pos;
	logic [IDX_W-1:0]    wrap_pos;
	logic [FADE_W:0]     fade_sum;
	logic [2*FACT_W-1:0] fact_sq;
	logic                out_load;
	logic                in_accept;

	// Handshake
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Selected slot, with zero frame time and zero frame count taken as one
	assign cur     = slots_q[slot_sel_q];
	assign ft_eff  = (cur.frame_time == '0) ? FT_W'(1) : cur.frame_time;
	assign fr_eff  = (cur.frames == '0) ? FR_W'(1) : cur.frames;
	assign slot_go = cur.occupied && !cur.manual && (slot_sel_q || (fade_q < dur_q));

	// Clamp and wrap candidates for the position update
	assign last_pos  = WRAP_W'(fr_eff - FR_W'(1)) << POS_FRAC_BITS;
	assign clamp_pos = (idx_q > IDX_W'(last_pos)) ? IDX_W'(last_pos) : idx_q;
	assign wrap_pos  = IDX_W'({div_rem_q[FR_W-1:0], idx_q[POS_FRAC_BITS-1:0]});

	// Fade timer sum and squared factor
	assign fade_sum = {1'b0, fade_q} + (FADE_W+1)'(item_q.tick_us);
	assign fact_sq  = fact_q * fact_q;

	// Shared restoring divider step: one quotient bit per cycle
	assign div_run = ((state_q == S_DIVD) || (state_q == S_DIVM) || (state_q == S_DIVF))
		&& (div_cnt_q != '0);
	assign div_sub = {1'b0, div_rem_q, div_num_q[DIV_NW-1]} - {2'b00, div_den_q};
	assign div_ge  = !div_sub[DIV_DW+1];

	// Sequencer: next state and divider loads
	always_comb begin
		state_d    = state_q;
		slot_done  = 1'b0;
		div_ld     = 1'b0;
		div_ld_num = '0;
		div_ld_den = '0;
		div_ld_cnt = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = (op_t'(item_q.operation) == OP_TICK) ? S_SLOT : S_FACTOR;
			end
			S_SLOT: begin
				if (slot_go) begin
					div_ld     = 1'b1;
					div_ld_num = DIV_NW'(item_q.tick_us) << (DIV_NW - DT_W);
					div_ld_den = DIV_DW'(ft_eff);
					div_ld_cnt = DIV_CNT_W'(DELTA_W);
					state_d    = S_DIVD;
				end else begin
					slot_done = 1'b1;
				end
			end
			S_DIVD: begin
				if (div_cnt_q == '0) state_d = S_ADD;
			end
			S_ADD: begin
				state_d = S_POS;
			end
			S_POS: begin
				if (cur.loops) begin
					div_ld     = 1'b1;
					div_ld_num = DIV_NW'(idx_q[IDX_W-1:POS_FRAC_BITS]) << (DIV_NW - HI_W);
					div_ld_den = DIV_DW'(fr_eff);
					div_ld_cnt = DIV_CNT_W'(HI_W);
					state_d    = S_DIVM;
				end else begin
					slot_done = 1'b1;
				end
			end
			S_DIVM: begin
				if (div_cnt_q == '0) state_d = S_WRAP;
			end
			S_WRAP: begin
				slot_done = 1'b1;
			end
			S_FADE: begin
				state_d = S_FACTOR;
			end
			S_FACTOR: begin
				if (dur_q == '0) begin
					state_d = S_OUT;
				end else begin
					div_ld     = 1'b1;
					div_ld_num = DIV_NW'(fade_q) << (DIV_NW - FADE_W);
					div_ld_den = DIV_DW'(dur_q);
					div_ld_cnt = DIV_CNT_W'(FNUM_W);
					state_d    = S_DIVF;
				end
			end
			S_DIVF: begin
				if (div_cnt_q == '0) state_d = S_SAT;
			end
			S_SAT: begin
				state_d = curve_q ? S_SQR : S_OUT;
			end
			S_SQR: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// Move from slot A to slot B, then on to the fade timer
		if (slot_done) state_d = slot_sel_q ? S_FADE : S_SLOT;
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_sel_q  <= 1'b0;
			fade_q      <= '0;
			dur_q       <= '0;
			curve_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_CNT; i++) begin
				slots_q[i] <= '0;
				pos_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;

			// Write configuration registers
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLEND_DURATION: dur_q   <= cfg_data[DUR_W-1:0];
					CFG_BLEND_CURVE:    curve_q <= cfg_data[0];
					default:            dur_q   <= dur_q;
				endcase
			end

			// Advance slot select
			if (state_q == S_EXEC) begin
				slot_sel_q <= 1'b0;
			end else if (slot_done) begin
				slot_sel_q <= 1'b1;
			end

			// Execute push, switch and set
			if (state_q == S_EXEC) begin
				unique case (op_t'(item_q.operation))
					OP_TICK: begin
						fade_q <= fade_q;
					end
					OP_PUSH: begin
						pos_q[1] <= '0;
						if (item_q.anim_present) begin
							slots_q[1] <= '{occupied: 1'b1,
								loops: item_q.anim_loops,
								manual: item_q.anim_manual,
								in_ok: item_q.anim_blend_in_ok,
								out_ok: item_q.anim_blend_out_ok,
								frames: item_q.anim_frames,
								frame_time: item_q.anim_frame_time_us};
						end else begin
							slots_q[1] <= '0;
						end
						// Force the fade to full when either side cannot blend
						if ((slots_q[0].occupied && !slots_q[0].out_ok) ||
							(item_q.anim_present && !item_q.anim_blend_in_ok)) begin
							fade_q <= dur_q;
						end
					end
					OP_SWITCH: begin
						slots_q[0] <= slots_q[1];
						pos_q[0]   <= pos_q[1];
						slots_q[1] <= '0;
						pos_q[1]   <= '0;
						fade_q     <= '0;
					end
					OP_SET: begin
						pos_q[item_q.target_slot] <= item_q.new_position;
					end
				endcase
			end

			// Store advanced positions
			if ((state_q == S_POS) && !cur.loops) begin
				pos_q[slot_sel_q] <= sat_pos(clamp_pos);
			end
			if (state_q == S_WRAP) begin
				pos_q[slot_sel_q] <= sat_pos(wrap_pos);
			end

			// Advance the fade timer, saturating at the duration
			if (state_q == S_FADE) begin
				fade_q <= (fade_sum < {1'b0, dur_q}) ? fade_sum[FADE_W-1:0] : dur_q;
			end

			// Hold the result until the downstream transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) item_q <= in_item;

		// Load or step the divider
		if (div_ld) begin
			div_num_q <= div_ld_num;
			div_den_q <= div_ld_den;
			div_rem_q <= '0;
			div_cnt_q <= div_ld_cnt;
		end else if (div_run) begin
			div_num_q <= {div_num_q[DIV_NW-2:0], div_ge};
			div_rem_q <= div_ge ? div_sub[DIV_DW-1:0]
				: {div_rem_q[DIV_DW-2:0], div_num_q[DIV_NW-1]};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end

		// Add the frame step to the position
		if (state_q == S_ADD) begin
			idx_q <= IDX_W'(pos_q[slot_sel_q]) + IDX_W'(div_num_q[DELTA_W-1:0]);
		end

		// Fade factor: one at zero duration, else saturate, then square when selected
		if ((state_q == S_FACTOR) && (dur_q == '0)) begin
			fact_q <= FACT_ONE;
		end
		if (state_q == S_SAT) begin
			fact_q <= (div_num_q[FNUM_W-1:0] > FNUM_W'(FACT_ONE)) ? FACT_ONE
				: div_num_q[FACT_W-1:0];
		end
		if (state_q == S_SQR) begin
			fact_q <= fact_sq[FACT_FRAC+FACT_W-1:FACT_FRAC];
		end

		// Capture the result
		if (out_load) begin
			out_item_q <= '{fade_factor: fact_q,
				position_a: pos_q[0],
				position_b: pos_q[1],
				a_occupied: slots_q[0].occupied,
				b_occupied: slots_q[1].occupied};
		end
	end

	// Accepted item always starts execution next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_EXEC))
		else $error("accepted item did not start execution");

	// Divider never runs against a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIVD) || (state_q == S_DIVM) || (state_q == S_DIVF))
		|-> (div_den_q != '0))
		else $error("divider running with zero divisor");

	// Fade factor is within 0..1.0 when the result is captured
	a_fact_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (fact_q <= FACT_ONE))
		else $error("fade factor above one");

	// A new result only appears from the output state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

endmodule

`default_nettype wire

>>> tb/dual_slot_animation_crossfade_tb.sv
// Self-checking testbench for the dual-slot animation crossfade block.
// Runs a short scripted sequence and then random tick, push, switch and set
// transfers against a cycle-free playback predictor. Depends on dsac_pkg.
module dual_slot_animation_crossfade_tb;
	import dsac_pkg::*;

	localparam int SLOT_A       = 0;
	localparam int SLOT_B       = 1;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 200;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 165;
	localparam int QUIET_PHASE  = 5;
	localparam int HOLD_PHASE   = 3;

	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_KNOWN,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		dsac_in_t    req;
		dsac_out_t   want;
		logic        reg_idx;
		logic [23:0] reg_val;
	} script_row_t;

	// Playback state of one slot as the predictor sees it
	typedef struct packed {
		logic            occupied;
		logic            loops;
		logic            manual;
		logic            in_ok;
		logic            out_ok;
		logic [FR_W-1:0] frames;
		logic [FT_W-1:0] frame_time;
		logic [POS_W-1:0] pos;
	} play_slot_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	dsac_in_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	dsac_out_t             out_item;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state and configuration
	play_slot_t       slots [SLOT_CNT];
	logic [FADE_W-1:0] fade_time;
	logic [DUR_W-1:0]  blend_len;
	logic              squared;

	dsac_out_t   expected_playback [$];
	script_row_t script [$];
	dsac_out_t   got_want;
	int          miss_count = 0;
	logic        quiet = 1'b0;
	int          hold_asked = 0;
	int          hold_given = 0;

	dual_slot_animation_crossfade DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Advance one slot by dt, wrapping or clamping at the clip end
	function automatic logic [POS_W-1:0] advance_position(input play_slot_t s,
			input logic [DT_W-1:0] dt);
		logic [63:0] ft, nfr, delta, p;
		ft    = (s.frame_time == 0) ? 64'd1 : 64'(s.frame_time);
		nfr   = (s.frames == 0) ? 64'd1 : 64'(s.frames);
		delta = (64'(dt) << POS_FRAC_BITS) / ft;
		p     = 64'(s.pos) + delta;
		if (s.loops) begin
			p = p % (nfr << POS_FRAC_BITS);
		end else if (p > ((nfr - 64'd1) << POS_FRAC_BITS)) begin
			p = (nfr - 64'd1) << POS_FRAC_BITS;
		end
		if (p > 64'hFFFF_FFFF) begin
			p = 64'hFFFF_FFFF;
		end
		return p[POS_W-1:0];
	endfunction

	// Weight of slot B from the fade timer
	function automatic logic [FACT_W-1:0] fade_weight();
		logic [63:0] f;
		if (blend_len == 0) begin
			return FACT_ONE;
		end
		f = (64'(fade_time) << FACT_FRAC) / 64'(blend_len);
		if (f > 64'(FACT_ONE)) begin
			f = 64'(FACT_ONE);
		end
		if (squared) begin
			f = (f * f) >> FACT_FRAC;
		end
		return f[FACT_W-1:0];
	endfunction

	// Apply one request to the predictor state and return the status it reports
	function automatic dsac_out_t predict_playback(input dsac_in_t r);
		dsac_out_t res;
		logic [FADE_W:0] fade_sum;
		case (op_t'(r.operation))
			OP_TICK: begin
				for (int s = 0; s < SLOT_CNT; s++) begin
					if (slots[s].occupied && !slots[s].manual &&
							!(s == SLOT_A && fade_time >= blend_len)) begin
						slots[s].pos = advance_position(slots[s], r.tick_us);
					end
				end
				fade_sum  = (FADE_W+1)'(fade_time) + (FADE_W+1)'(r.tick_us);
				fade_time = (fade_sum < {1'b0, blend_len}) ? fade_sum[FADE_W-1:0] : blend_len;
			end
			OP_PUSH: begin
				slots[SLOT_B] = '0;
				if (r.anim_present) begin
					slots[SLOT_B].occupied   = 1'b1;
					slots[SLOT_B].loops      = r.anim_loops;
					slots[SLOT_B].manual     = r.anim_manual;
					slots[SLOT_B].in_ok      = r.anim_blend_in_ok;
					slots[SLOT_B].out_ok     = r.anim_blend_out_ok;
					slots[SLOT_B].frames     = r.anim_frames;
					slots[SLOT_B].frame_time = r.anim_frame_time_us;
				end
				// skip the fade when either side refuses to blend
				if ((slots[SLOT_A].occupied && !slots[SLOT_A].out_ok) ||
						(slots[SLOT_B].occupied && !slots[SLOT_B].in_ok)) begin
					fade_time = blend_len;
				end
			end
			OP_SWITCH: begin
				slots[SLOT_A] = slots[SLOT_B];
				slots[SLOT_B] = '0;
				fade_time     = '0;
			end
			default: begin
				slots[r.target_slot].pos = r.new_position;
			end
		endcase
		res.fade_factor = fade_weight();
		res.position_a  = slots[SLOT_A].pos;
		res.position_b  = slots[SLOT_B].pos;
		res.a_occupied  = slots[SLOT_A].occupied;
		res.b_occupied  = slots[SLOT_B].occupied;
		return res;
	endfunction

	function automatic dsac_in_t tick_req(input logic [DT_W-1:0] dt);
		dsac_in_t r;
		r           = '0;
		r.operation = OP_TICK;
		r.tick_us   = dt;
		return r;
	endfunction

	// fl holds {loops, manual, blend in ok, blend out ok}
	function automatic dsac_in_t push_req(input logic present, input logic [FR_W-1:0] frames,
			input logic [FT_W-1:0] ft, input logic [3:0] fl);
		dsac_in_t r;
		r                    = '0;
		r.operation          = OP_PUSH;
		r.anim_present       = present;
		r.anim_frames        = frames;
		r.anim_frame_time_us = ft;
		{r.anim_loops, r.anim_manual, r.anim_blend_in_ok, r.anim_blend_out_ok} = fl;
		return r;
	endfunction

	function automatic dsac_in_t set_req(input logic slot, input logic [POS_W-1:0] pos);
		dsac_in_t r;
		r              = '0;
		r.operation    = OP_SET;
		r.target_slot  = slot;
		r.new_position = pos;
		return r;
	endfunction

	function automatic dsac_in_t switch_req();
		dsac_in_t r;
		r           = '0;
		r.operation = OP_SWITCH;
		return r;
	endfunction

	function automatic void add_row(input dsac_in_t r);
		script.push_back('{ROW_PREDICTED, r, '0, 1'b0, '0});
	endfunction

	function automatic void add_known(input dsac_in_t r, input dsac_out_t w);
		script.push_back('{ROW_KNOWN, r, w, 1'b0, '0});
	endfunction

	function automatic void add_reg(input logic idx, input logic [23:0] v);
		script.push_back('{ROW_REG, '0, '0, idx, v});
	endfunction

	// Random request: mostly playback-sized values, some full-range noise
	function automatic dsac_in_t random_request();
		dsac_in_t r;
		int unsigned roll, span;
		r    = dsac_in_t'({$urandom, $urandom, $urandom});
		roll = $urandom_range(99);
		if (roll < 45) begin
			r.operation = OP_TICK;
		end else if (roll < 65) begin
			r.operation = OP_PUSH;
		end else if (roll < 77) begin
			r.operation = OP_SWITCH;
		end else begin
			r.operation = OP_SET;
		end
		if ($urandom_range(4) != 0) begin
			span = 32'(blend_len / 8) + 32'd1;
			if (span > 32'hFFFFF) begin
				span = 32'hFFFFF;
			end
			r.tick_us = DT_W'($urandom_range(span));
		end
		if ($urandom_range(3) != 0) begin
			r.anim_frames = FR_W'($urandom_range(16, 1));
		end else if (r.anim_frames == '0) begin
			r.anim_frames = FR_W'(1);
		end
		if ($urandom_range(3) != 0) begin
			r.anim_frame_time_us = FT_W'($urandom_range(2000, 1));
		end else if (r.anim_frame_time_us == '0) begin
			r.anim_frame_time_us = FT_W'(1);
		end
		r.anim_present      = ($urandom_range(9) != 0);
		r.anim_manual       = ($urandom_range(5) == 0);
		r.anim_blend_in_ok  = ($urandom_range(3) != 0);
		r.anim_blend_out_ok = ($urandom_range(3) != 0);
		if ($urandom_range(1) == 0) begin
			r.new_position = $urandom_range(32'h000F_FFFF);
		end
		return r;
	endfunction

	// Offer one request, hold it until the transfer, then record the expected status
	task automatic send_request(input dsac_in_t r, input logic known, input dsac_out_t w);
		dsac_out_t predicted;
		cfg_we <= 1'b0;
		if (!quiet && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= r;
		do @(posedge clk); while (in_stall);
		predicted = predict_playback(r);
		expected_playback.push_back(known ? w : predicted);
	endtask

	// Write one register once every pending status has come back
	task automatic write_reg(input logic idx, input logic [23:0] v);
		in_valid <= 1'b0;
		while (expected_playback.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		if (idx == CFG_BLEND_DURATION) begin
			blend_len = v;
		end else begin
			squared = v[0];
		end
	endtask

	task automatic note_miss(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (miss_count < 10) begin
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
		end
		miss_count++;
	endtask

	// Receiver: random stalls, a quiet phase and one long hold-off
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_given != hold_asked) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_given++;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 13);
			end
		end
	end

	// Compare each status transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_playback.size() == 0) begin
				note_miss("status with nothing pending", '0, 32'(out_item.fade_factor));
			end else begin
				got_want = expected_playback.pop_front();
				if (got_want.fade_factor !== out_item.fade_factor)
					note_miss("fade_factor", 32'(got_want.fade_factor),
						32'(out_item.fade_factor));
				if (got_want.position_a !== out_item.position_a)
					note_miss("position_a", got_want.position_a, out_item.position_a);
				if (got_want.position_b !== out_item.position_b)
					note_miss("position_b", got_want.position_b, out_item.position_b);
				if (got_want.a_occupied !== out_item.a_occupied)
					note_miss("a_occupied", 32'(got_want.a_occupied),
						32'(out_item.a_occupied));
				if (got_want.b_occupied !== out_item.b_occupied)
					note_miss("b_occupied", 32'(got_want.b_occupied),
						32'(out_item.b_occupied));
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [23:0] dur;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data  <= '0;
		slots[SLOT_A] = '0;
		slots[SLOT_B] = '0;
		fade_time     = '0;
		blend_len     = '0;
		squared       = 1'b0;

		// Scripted part: reset state, extremes, every operation, special cases
		add_known(tick_req(0), '{FACT_ONE, 32'd0, 32'd0, 1'b0, 1'b0});
		add_known(set_req(1'b0, 32'hFFFF_FFFF), '{FACT_ONE, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0});
		add_row(set_req(1'b1, 32'd12345));
		// empty push clears slot B, including a position set on it
		add_known(push_req(1'b0, 16'hFFFF, 20'hFFFFF, 4'b1111),
			'{FACT_ONE, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0});
		add_reg(CFG_BLEND_DURATION, 24'd1000);
		add_reg(CFG_BLEND_CURVE, 24'd0);
		add_row(push_req(1'b1, 16'hFFFF, 20'hFFFFF, 4'b1011));
		add_row(tick_req(20'hFFFFF));
		add_row(switch_req());
		add_row(push_req(1'b1, 16'd1, 20'd1, 4'b0011));
		add_row(tick_req(20'd500));
		add_reg(CFG_BLEND_CURVE, 24'd1);
		add_row(tick_req(20'd0));
		add_row(set_req(1'b1, 32'hFFFF_FFFF));
		add_row(tick_req(20'd1));
		// B refuses to blend in: fade jumps to full
		add_row(push_req(1'b1, 16'd3, 20'd7, 4'b1100));
		add_row(tick_req(20'd100));
		add_row(switch_req());
		// manual A refuses to blend out
		add_row(push_req(1'b1, 16'd2, 20'd3, 4'b1011));
		add_reg(CFG_BLEND_DURATION, 24'hFFFFFF);
		// zero frame count, then zero frame time
		add_row(push_req(1'b1, 16'd0, 20'd9, 4'b0011));
		add_row(tick_req(20'hFFFFF));
		add_row(push_req(1'b1, 16'd50, 20'd0, 4'b1011));
		add_row(tick_req(20'd7));
		// lowered duration: factor saturates, timer drops on the next tick
		add_reg(CFG_BLEND_DURATION, 24'd10);
		add_row(tick_req(20'd0));
		add_row(push_req(1'b1, 16'hFFFF, 20'd1, 4'b0011));
		add_row(tick_req(20'hFFFFF));
		add_row(set_req(1'b0, 32'd0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_REG:   write_reg(script[i].reg_idx, script[i].reg_val);
				ROW_KNOWN: send_request(script[i].req, 1'b1, script[i].want);
				default:   send_request(script[i].req, 1'b0, '0);
			endcase
		end

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       dur = 24'd0;
				1:       dur = 24'hFFFFFF;
				2:       dur = 24'd1;
				3:       dur = 24'($urandom_range(5000, 100));
				default: dur = 24'($urandom_range(200000, 1));
			endcase
			write_reg(CFG_BLEND_DURATION, dur);
			write_reg(CFG_BLEND_CURVE, 24'(phase % 2));
			quiet <= (phase == QUIET_PHASE);
			if (phase == HOLD_PHASE) begin
				hold_asked <= hold_asked + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_request(random_request(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (expected_playback.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (expected_playback.size() != 0) begin
			note_miss("statuses never returned", '0, 32'(expected_playback.size()));
		end
		if (miss_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
